// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the scheduler.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PTS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pts_pkg.sv
// Shared types and constants of the periodic task scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package pts_pkg;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_SCHED    = 3'd1,
    MODE_CREATE   = 3'd2,
    MODE_DELETE   = 3'd3,
    MODE_ACTIVATE = 3'd4,
    MODE_SUSPEND  = 3'd5,
    MODE_DELAY    = 3'd6
  } mode_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_REJECT     = 2'd1;
  localparam logic [1:0] ST_NO_HANDLER = 2'd2;

  localparam logic [2:0] IDLE_RESET = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_CMD,
    RD_RUN,
    RD_SCAN
  } rd_src_t;

  typedef struct packed {
    logic [31:0] wake;
    logic [15:0] cnt;
    logic [15:0] per;
  } row_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_src_t rd_src;
    logic    exec;
    logic    proc;
    logic    result_load;
  } ctl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  pick_hit;
    logic  out_busy;
  } ctl_sts_t;

endpackage

// File: rtl/pts_ctrl.sv
// Controller of the scheduler: sequences accept, slot read, edit, scan and result.
// Depends on pts_pkg; drives the datapath through ctl_cmd_t and reads ctl_sts_t.
module pts_ctrl import pts_pkg::*; #(
  parameter int TASKS = 8,
  localparam int IW = $clog2(TASKS),
  localparam int CW = $clog2(TASKS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ctl_sts_t       sts,
  output ctl_cmd_t       cmd,
  output logic [IW-1:0]  scan_addr
);

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign scan_addr = idx_r[IW-1:0];

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = (sts.mode == MODE_DELAY) ? RD_RUN : RD_CMD;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.mode) inside
          MODE_TICK, MODE_SCHED, MODE_DELAY: begin
            state_nxt = S_SCAN;
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        // Slot i is processed in the cycle that slot i+1 is read.
        cmd.proc   = pend_r;
        cmd.rd_src = RD_SCAN;
        cmd.rd_en  = (idx_r < CW'(TASKS));
        if (pend_r && sts.pick_hit) begin
          state_nxt = S_DONE;
        end else if (!cmd.rd_en) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.result_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/pts_dp.sv
// Datapath of the scheduler: slot table, tick count, current task and result register.
// Depends on pts_pkg; steered by pts_ctrl through ctl_cmd_t.
module pts_dp import pts_pkg::*; #(
  parameter int TASKS = 8,
  localparam int IW = $clog2(TASKS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctl_cmd_t      cmd,
  input  logic [IW-1:0] scan_addr,
  output ctl_sts_t      sts,
  input  logic [2:0]    in_mode,
  input  logic [7:0]    in_task_id,
  input  logic          in_handler_given,
  input  logic [15:0]   in_period,
  input  logic [7:0]    in_first_delay,
  input  logic [15:0]   in_delay_ticks,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_wdata,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_current_task,
  output logic          out_picked,
  output logic [1:0]    out_status,
  output logic [31:0]   out_tick_now
);

  // Latched input beat.
  mode_t       mode_r;
  logic [7:0]  id_r;
  logic        hnd_r;
  logic [15:0] per_r;
  logic [7:0]  first_r;
  logic [15:0] dly_r;

  // Slot table: flag bits in flops, the wide fields in a one-row-per-slot memory.
  logic [TASKS-1:0] present_r, present_nxt;
  logic [TASKS-1:0] active_r, active_nxt;
  logic [TASKS-1:0] row_vld_r, row_vld_nxt;
  row_t             slot_mem_r [TASKS];
  row_t             rd_data_r;
  logic             rd_vld_r;
  logic [IW-1:0]    row_idx_r;

  logic [31:0]   tick_r, tick_nxt;
  logic [IW-1:0] run_r, run_nxt;
  logic          picked_r, picked_nxt;
  logic [1:0]    status_r, status_nxt;

  logic          out_valid_r;
  logic [2:0]    out_cur_r;
  logic          out_picked_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_tick_r;

  row_t          row, wr_row;
  logic          wr_en;
  logic          pick_hit;
  logic          id_in, run_in, cmd_present, cmd_ok;
  logic [IW-1:0] cmd_slot, run_slot, rd_addr;

  assign id_in       = (id_r < 8'(TASKS));
  assign run_in      = ({1'b0, run_r} < (IW + 1)'(TASKS));
  assign cmd_slot    = id_in ? id_r[IW-1:0] : '0;
  assign run_slot    = run_in ? run_r : '0;
  assign cmd_present = present_r[cmd_slot];
  assign cmd_ok      = id_in && cmd_present;

  // A row never written reads as all zero.
  assign row = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    case (cmd.rd_src)
      RD_CMD:  rd_addr = cmd_slot;
      RD_RUN:  rd_addr = run_slot;
      RD_SCAN: rd_addr = scan_addr;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    present_nxt = present_r;
    active_nxt  = active_r;
    row_vld_nxt = row_vld_r;
    tick_nxt    = tick_r;
    run_nxt     = run_r;
    picked_nxt  = picked_r;
    status_nxt  = status_r;
    wr_en       = 1'b0;
    wr_row      = row;
    pick_hit    = 1'b0;

    if (cmd.load) begin
      picked_nxt = 1'b0;
      status_nxt = ST_OK;
    end

    if (cmd.exec) begin
      case (mode_r)
        MODE_TICK:  tick_nxt = tick_r + 32'd1;
        MODE_SCHED: ;
        MODE_CREATE: begin
          if (!hnd_r) begin
            status_nxt = ST_NO_HANDLER;
          end else if (!id_in || cmd_present) begin
            status_nxt = ST_REJECT;
          end else begin
            present_nxt[cmd_slot] = 1'b1;
            active_nxt[cmd_slot]  = 1'b1;
            wr_row.wake = '0;
            wr_row.cnt  = {8'd0, first_r};
            wr_row.per  = per_r;
            wr_en       = 1'b1;
          end
        end
        MODE_DELETE: begin
          if (!cmd_ok) begin
            status_nxt = ST_REJECT;
          end else begin
            present_nxt[cmd_slot] = 1'b0;
            active_nxt[cmd_slot]  = 1'b0;
            wr_row.per = '0;
            wr_en      = 1'b1;
          end
        end
        MODE_ACTIVATE: begin
          if (!cmd_ok) status_nxt = ST_REJECT;
          else         active_nxt[cmd_slot] = 1'b1;
        end
        MODE_SUSPEND: begin
          if (!cmd_ok) status_nxt = ST_REJECT;
          else         active_nxt[cmd_slot] = 1'b0;
        end
        MODE_DELAY: begin
          if (run_in) begin
            wr_row.wake = tick_r + {16'd0, dly_r};
            wr_en       = 1'b1;
            active_nxt[run_slot] = 1'b0;
          end
        end
        default: status_nxt = ST_REJECT;
      endcase
    end

    if (cmd.proc) begin
      if (active_r[row_idx_r]) begin
        if (row.cnt == 16'd0) begin
          // An active slot at count zero that is no longer present is passed over untouched.
          if (present_r[row_idx_r]) begin
            pick_hit   = 1'b1;
            picked_nxt = 1'b1;
            run_nxt    = row_idx_r;
            wr_row.cnt = row.per;
            wr_en      = 1'b1;
          end
        end else begin
          wr_row.cnt = row.cnt - 16'd1;
          wr_en      = 1'b1;
        end
      end else if (row.wake != 32'd0 && row.wake <= tick_r) begin
        active_nxt[row_idx_r] = 1'b1;
        wr_row.wake = '0;
        wr_en       = 1'b1;
      end
    end

    if (wr_en) row_vld_nxt[row_idx_r] = 1'b1;

    if (cfg_we) run_nxt = IW'(cfg_wdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      active_r    <= '0;
      row_vld_r   <= '0;
      tick_r      <= '0;
      run_r       <= IW'(IDLE_RESET);
      out_valid_r <= 1'b0;
    end else begin
      present_r <= present_nxt;
      active_r  <= active_nxt;
      row_vld_r <= row_vld_nxt;
      tick_r    <= tick_nxt;
      run_r     <= run_nxt;
      if (cmd.result_load)  out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_mem_r[row_idx_r] <= wr_row;
    if (cmd.rd_en) begin
      rd_data_r <= slot_mem_r[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
      row_idx_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    picked_r <= picked_nxt;
    status_r <= status_nxt;
    if (cmd.load) begin
      mode_r  <= mode_t'(in_mode);
      id_r    <= in_task_id;
      hnd_r   <= in_handler_given;
      per_r   <= in_period;
      first_r <= in_first_delay;
      dly_r   <= in_delay_ticks;
    end
    if (cmd.result_load) begin
      out_cur_r    <= run_r[2:0];
      out_picked_r <= picked_r;
      out_status_r <= status_r;
      out_tick_r   <= tick_r;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.pick_hit = pick_hit;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_current_task = out_cur_r;
  assign out_picked       = out_picked_r;
  assign out_status       = out_status_r;
  assign out_tick_now     = out_tick_r;

endmodule

// File: rtl/periodic_task_scheduler_top.sv
// Top level of the periodic task scheduler: controller plus datapath.
// Depends on pts_pkg, pts_ctrl and pts_dp.
//
//   Channel  Direction  Handshake            Carries
//   in_      input      in_valid/in_ready    mode, task_id, handler_given, period,
//                                            first_delay, delay_ticks
//   out_     output     out_valid/out_ready  current_task, picked, status, tick_now
//   cfg_     input      cfg_we               idle_task (cfg_wdata)
//
// One beat is worked on at a time. A slot edit runs through the read, exec and done
// states; tick, schedule and delay add a scan before done, the pass that
// reads one slot a cycle from the slot memory (one read and one write port).
// Reset (rst_n low, synchronous) clears the slot flags and tick count and makes
// slot 4 current. A result waiting in the output register does not block the
// next accept; only a second result waits for out_ready.
module periodic_task_scheduler_top import pts_pkg::*; #(
  parameter int TASKS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_task_id,
  input  logic        in_handler_given,
  input  logic [15:0] in_period,
  input  logic [7:0]  in_first_delay,
  input  logic [15:0] in_delay_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_current_task,
  output logic        out_picked,
  output logic [1:0]  out_status,
  output logic [31:0] out_tick_now,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);

  localparam int IW = $clog2(TASKS);

  ctl_cmd_t      cmd;
  ctl_sts_t      sts;
  logic [IW-1:0] scan_addr;

  pts_ctrl #(.TASKS(TASKS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd),
    .scan_addr (scan_addr)
  );

  pts_dp #(.TASKS(TASKS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .scan_addr        (scan_addr),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_task_id       (in_task_id),
    .in_handler_given (in_handler_given),
    .in_period        (in_period),
    .in_first_delay   (in_first_delay),
    .in_delay_ticks   (in_delay_ticks),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_current_task (out_current_task),
    .out_picked       (out_picked),
    .out_status       (out_status),
    .out_tick_now     (out_tick_now)
  );

endmodule

// File: rtl/pts_chk.sv
// Port-level checker for the scheduler top, attached by the bind at the end.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_picked,
  input logic [1:0]  out_status,
  input logic [31:0] out_tick_now
);

  `PTS_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid straight after reset")
  `PTS_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second beat taken during work")
  `PTS_ASSERT(a_status, out_valid |-> out_status != 2'd3, "undefined status code")
  `PTS_ASSERT(a_pick_ok, out_valid && out_picked |-> out_status == 2'd0, "pick with bad status")
  `PTS_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_tick_now), "stall lost")

endmodule

bind periodic_task_scheduler_top pts_chk u_pts_chk (.*);
